// ----- sv/local_binary_pattern_3x3_unit_defines.svh -----
// Assertion macros shared by the local binary pattern unit.
// No dependencies; included by the modules that check their own logic.
`ifndef LOCAL_BINARY_PATTERN_3X3_UNIT_DEFINES_SVH
`define LOCAL_BINARY_PATTERN_3X3_UNIT_DEFINES_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent.
`define LBP3_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lbp3 check failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define LBP3_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lbp3 check failed: next-cycle implication");

`else

`define LBP3_ASSERT_SAME(label, clk, rst, ante, cons)

`define LBP3_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- sv/lbp3_pkg.sv -----
// Shared types and constants of the local binary pattern unit.
// No dependencies; used by every module of the unit.
package lbp3_pkg;

   localparam int PIX_W            = 8;
   localparam int DIM_W            = 11;
   localparam int CSR_IDX_W        = 1;
   localparam int DEF_MAX_WIDTH    = 1024;
   localparam int DEF_MAX_HEIGHT   = 1024;
   localparam int RST_FRAME_WIDTH  = 640;
   localparam int RST_FRAME_HEIGHT = 480;
   localparam int QUEUE_DEPTH      = 4;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   // One column of the window plus its classification, front to back
   typedef struct packed {
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] bot;
      logic             emit;
      logic             last;
   } item_type;

endpackage

// ----- sv/lbp3_front.sv -----
// Front end: accepts pixels, tracks position, keeps the two line stores.
// Depends on lbp3_pkg; feeds classified columns into lbp3_queue.
`include "local_binary_pattern_3x3_unit_defines.svh"

module lbp3_front #(
   parameter int MAX_WIDTH  = lbp3_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = lbp3_pkg::DEF_MAX_HEIGHT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [lbp3_pkg::PIX_W-1:0]         req_pixel,
   input  logic                               csr_write_en,
   input  logic [lbp3_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lbp3_pkg::DIM_W-1:0]         csr_write_data,
   input  logic                               q_full,
   output logic                               q_push,
   output lbp3_pkg::item_type                 q_item
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int WX  = (CW + 1 > lbp3_pkg::DIM_W) ? CW + 1 : lbp3_pkg::DIM_W;
   localparam int HX  = (RW + 1 > lbp3_pkg::DIM_W) ? RW + 1 : lbp3_pkg::DIM_W;
   localparam int RST_W = (lbp3_pkg::RST_FRAME_WIDTH > MAX_WIDTH) ?
                          MAX_WIDTH : lbp3_pkg::RST_FRAME_WIDTH;
   localparam int RST_H = (lbp3_pkg::RST_FRAME_HEIGHT > MAX_HEIGHT) ?
                          MAX_HEIGHT : lbp3_pkg::RST_FRAME_HEIGHT;
   localparam int PW  = lbp3_pkg::PIX_W;

   logic [CW-1:0]   w_m1_ff, w_m1_in;
   logic [RW-1:0]   h_m1_ff, h_m1_in;
   logic [WX-1:0]   wd_ext;
   logic [HX-1:0]   hd_ext;
   logic [CW-1:0]   col_ff, col_in, col_cur;
   logic [RW-1:0]   row_ff, row_in, row_cur;
   logic            accept;
   logic            s1_valid_ff, s1_valid_in;
   logic [PW-1:0]   s1_pix_ff;
   logic [CW-1:0]   s1_col_ff;
   logic            s1_emit_ff;
   logic            s1_last_ff;
   logic [2*PW-1:0] rd_ff;
   logic [2*PW-1:0] line_mem [MAX_WIDTH];

   // Saturate written dimensions and keep them as last index
   always_comb begin
      wd_ext = WX'(csr_write_data);
      hd_ext = HX'(csr_write_data);
      w_m1_in = w_m1_ff;
      h_m1_in = h_m1_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            lbp3_pkg::CSR_FRAME_WIDTH: begin
               if (wd_ext < WX'(3)) w_m1_in = CW'(2);
               else if (wd_ext > WX'(MAX_WIDTH)) w_m1_in = CW'(MAX_WIDTH - 1);
               else w_m1_in = CW'(wd_ext - WX'(1));
            end
            lbp3_pkg::CSR_FRAME_HEIGHT: begin
               if (hd_ext < HX'(3)) h_m1_in = RW'(2);
               else if (hd_ext > HX'(MAX_HEIGHT)) h_m1_in = RW'(MAX_HEIGHT - 1);
               else h_m1_in = RW'(hd_ext - HX'(1));
            end
            default: ;
         endcase
      end
   end

   // Handshake: hold the input while the staged transaction cannot drain
   assign req_stall = s1_valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign q_push    = s1_valid_ff && !q_full;

   // Position of this pixel, pulled back inside a shrunken frame
   always_comb begin
      col_cur = (col_ff > w_m1_ff) ? w_m1_ff : col_ff;
      row_cur = (row_ff > h_m1_ff) ? h_m1_ff : row_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      if (accept) begin
         if (col_cur == w_m1_ff) begin
            col_in = '0;
            row_in = (row_cur == h_m1_ff) ? '0 : row_cur + RW'(1);
         end else begin
            col_in = col_cur + CW'(1);
            row_in = row_cur;
         end
      end
      s1_valid_in = accept ? 1'b1 : (q_push ? 1'b0 : s1_valid_ff);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         w_m1_ff     <= CW'(RST_W - 1);
         h_m1_ff     <= RW'(RST_H - 1);
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         w_m1_ff     <= w_m1_in;
         h_m1_ff     <= h_m1_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Stage the accepted transaction and classify it
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff  <= req_pixel;
         s1_col_ff  <= col_cur;
         s1_emit_ff <= (row_cur >= RW'(2)) && (col_cur >= CW'(2));
         s1_last_ff <= (row_cur == h_m1_ff) && (col_cur == w_m1_ff);
      end
   end

   // Line stores: one entry holds {two rows up, one row up}; read on accept,
   // rotate in the new pixel when the staged transaction moves on
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= line_mem[col_cur];
      end
      if (q_push) begin
         line_mem[s1_col_ff] <= {rd_ff[PW-1:0], s1_pix_ff};
      end
   end

   assign q_item.top  = rd_ff[2*PW-1:PW];
   assign q_item.mid  = rd_ff[PW-1:0];
   assign q_item.bot  = s1_pix_ff;
   assign q_item.emit = s1_emit_ff;
   assign q_item.last = s1_last_ff;

   `LBP3_ASSERT_NEXT(a_accept_stages, clock, reset, accept, s1_valid_ff)
   `LBP3_ASSERT_SAME(a_last_emits, clock, reset, q_push && q_item.last, q_item.emit)

endmodule

// ----- sv/lbp3_queue.sv -----
// Short queue of classified columns between front and back end.
// Depends on lbp3_pkg for the item type.
`include "local_binary_pattern_3x3_unit_defines.svh"

module lbp3_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lbp3_pkg::item_type push_item,
   input  logic               pop,
   output lbp3_pkg::item_type head_item,
   output logic               not_empty,
   output logic               full
);

   localparam int DEPTH = lbp3_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   lbp3_pkg::item_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign head_item = entry_ff[rd_ptr_ff];

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed transaction
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   `LBP3_ASSERT_SAME(a_no_pop_empty, clock, reset, pop, count_ff != '0)
   `LBP3_ASSERT_SAME(a_no_push_full, clock, reset, push, count_ff != CNT_W'(DEPTH))

endmodule

// ----- sv/lbp3_back.sv -----
// Back end: slides the 3x3 window, forms the pattern code, holds the result.
// Depends on lbp3_pkg; drains lbp3_queue.
`include "local_binary_pattern_3x3_unit_defines.svh"

module lbp3_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_not_empty,
   input  lbp3_pkg::item_type         q_head,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [lbp3_pkg::PIX_W-1:0] rsp_pattern_code,
   output logic                       rsp_frame_last
);

   localparam int PW = lbp3_pkg::PIX_W;

   // Left and center columns of the window; the right column is the queue head
   logic [PW-1:0] ctr_top_ff, ctr_mid_ff, ctr_bot_ff;
   logic [PW-1:0] rgt_top_ff, rgt_mid_ff, rgt_bot_ff;
   logic [PW-1:0] code;
   logic [PW-1:0] centre;
   logic          out_free;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0] code_ff;
   logic          last_ff;

   // Drop columns that give no code even while the output is stalled
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign q_pop    = q_not_empty && (!q_head.emit || out_free);

   // Compare the eight neighbors of the window after this shift
   always_comb begin
      centre  = rgt_mid_ff;
      code[7] = ctr_top_ff > centre;
      code[6] = rgt_top_ff > centre;
      code[5] = q_head.top > centre;
      code[4] = q_head.mid > centre;
      code[3] = q_head.bot > centre;
      code[2] = rgt_bot_ff > centre;
      code[1] = ctr_bot_ff > centre;
      code[0] = ctr_mid_ff > centre;
      if (q_pop && q_head.emit) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Advance the window and load the result register
   always_ff @(posedge clock) begin
      if (q_pop) begin
         ctr_top_ff <= rgt_top_ff;
         ctr_mid_ff <= rgt_mid_ff;
         ctr_bot_ff <= rgt_bot_ff;
         rgt_top_ff <= q_head.top;
         rgt_mid_ff <= q_head.mid;
         rgt_bot_ff <= q_head.bot;
      end
      if (q_pop && q_head.emit) begin
         code_ff <= code;
         last_ff <= q_head.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pattern_code = code_ff;
   assign rsp_frame_last   = last_ff;

   `LBP3_ASSERT_NEXT(a_emit_shows, clock, reset, q_pop && q_head.emit, rsp_valid_ff)
   `LBP3_ASSERT_SAME(a_no_overwrite, clock, reset,
                     rsp_valid_ff && rsp_stall, !(q_pop && q_head.emit))

endmodule

// ----- sv/local_binary_pattern_3x3_unit.sv -----
// Top level of the streaming 3x3 local binary pattern unit.
// Depends on lbp3_pkg, lbp3_front, lbp3_queue and lbp3_back.
//
// Takes one 8-bit grayscale pixel per clock in raster order and gives one
// 8-bit pattern code for every interior pixel of the frame (bit 7 top-left,
// clockwise, bit 0 left; a bit is set when that neighbor is greater than
// the center); border pixels give none, and the code caused by the last
// pixel of the frame carries rsp_frame_last. Throughput is one pixel per
// cycle unless stalled: the line store is a single-port-read,
// single-port-write memory of MAX_WIDTH entries that is read once and
// written once per pixel. A code passes the staging register, the queue
// and the result register. A four-entry queue separates the position/line
// store front end from the window/compare back end, so a short stall on the
// result side does not stop the pixel input. Frame width and height
// (register 0 and 1) are saturated to 3..MAX_WIDTH and 3..MAX_HEIGHT and
// may be written only while the unit is idle.
module local_binary_pattern_3x3_unit #(
   parameter int MAX_WIDTH  = lbp3_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = lbp3_pkg::DEF_MAX_HEIGHT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [lbp3_pkg::PIX_W-1:0]     req_pixel,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [lbp3_pkg::PIX_W-1:0]     rsp_pattern_code,
   output logic                           rsp_frame_last,
   input  logic                           csr_write_en,
   input  logic [lbp3_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lbp3_pkg::DIM_W-1:0]     csr_write_data
);

   logic               q_full;
   logic               q_push;
   logic               q_pop;
   logic               q_not_empty;
   lbp3_pkg::item_type q_item;
   lbp3_pkg::item_type q_head;

   lbp3_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel      (req_pixel),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_item         (q_item)
   );

   lbp3_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .pop       (q_pop),
      .head_item (q_head),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   lbp3_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_not_empty      (q_not_empty),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pattern_code (rsp_pattern_code),
      .rsp_frame_last   (rsp_frame_last)
   );

endmodule

// ----- tb/tb_local_binary_pattern_3x3_unit.sv -----
// Self-checking testbench for the streaming 3x3 local binary pattern unit.
// Depends on lbp3_pkg and local_binary_pattern_3x3_unit; reads no files.
// A local pattern predictor checks every code and frame-end flag in order.
module tb_local_binary_pattern_3x3_unit;

   localparam int          PIX_W          = lbp3_pkg::PIX_W;
   localparam int          DIM_W          = lbp3_pkg::DIM_W;
   localparam int          CSR_IDX_W      = lbp3_pkg::CSR_IDX_W;
   localparam int          MAX_W          = lbp3_pkg::DEF_MAX_WIDTH;
   localparam int          MAX_H          = lbp3_pkg::DEF_MAX_HEIGHT;
   localparam int          RANDOM_PIXELS  = 820;
   localparam int          EXTREME_PIXELS = 60;
   localparam int          SETTLE_CYCLES  = 16;
   localparam int          IDLE_GUARD     = 20000;
   localparam int unsigned CYCLE_LIMIT    = 1000000;

   typedef struct packed {
      logic [PIX_W-1:0] code;
      logic             last;
   } pattern_result_type;

   typedef enum int {FILL_RANDOM, FILL_NEAR, FILL_FLAT, FILL_EXTREME} fill_kind_type;

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_stall;
   logic [PIX_W-1:0]     req_pixel      = '0;
   logic                 rsp_valid;
   logic                 rsp_stall      = 1'b0;
   logic [PIX_W-1:0]     rsp_pattern_code;
   logic                 rsp_frame_last;
   logic                 csr_write_en   = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index      = lbp3_pkg::CSR_FRAME_WIDTH;
   logic [DIM_W-1:0]     csr_write_data = '0;

   // Predictor state: line stores, window, position and register copies
   logic [PIX_W-1:0]   older_row [MAX_W];
   logic [PIX_W-1:0]   newer_row [MAX_W];
   logic [PIX_W-1:0]   nbhd [9];
   int unsigned        col_pos;
   int unsigned        row_pos;
   logic [DIM_W-1:0]   width_reg;
   logic [DIM_W-1:0]   height_reg;
   pattern_result_type pending_codes [$];

   int unsigned cycle_count     = 0;
   int unsigned error_count     = 0;
   int unsigned pixels_accepted = 0;
   int unsigned codes_checked   = 0;
   int unsigned frames_done     = 0;
   bit          tx_idle_on      = 1'b1;
   bit          rx_idle_on      = 1'b1;
   int          hold_request    = 0;

   local_binary_pattern_3x3_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel        (req_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pattern_code (rsp_pattern_code),
      .rsp_frame_last   (rsp_frame_last),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   // Saturate a frame dimension register to its usable range
   function automatic int unsigned eff_dim(logic [DIM_W-1:0] v, int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void reset_prediction();
      int i;
      for (i = 0; i < MAX_W; i++) begin
         older_row[i] = '0;
         newer_row[i] = '0;
      end
      for (i = 0; i < 9; i++) nbhd[i] = '0;
      col_pos    = 0;
      row_pos    = 0;
      width_reg  = DIM_W'(lbp3_pkg::RST_FRAME_WIDTH);
      height_reg = DIM_W'(lbp3_pkg::RST_FRAME_HEIGHT);
   endfunction

   // Advance the predictor by one pixel and queue the code it completes
   function automatic void predict_pixel(logic [PIX_W-1:0] px);
      int unsigned        w;
      int unsigned        h;
      int unsigned        c;
      int unsigned        r;
      logic [PIX_W-1:0]   up2;
      logic [PIX_W-1:0]   up1;
      logic [PIX_W-1:0]   ctr;
      pattern_result_type res;
      w = eff_dim(width_reg, MAX_W);
      h = eff_dim(height_reg, MAX_H);
      if (col_pos >= w) col_pos = w - 1;
      if (row_pos >= h) row_pos = h - 1;
      c = col_pos;
      r = row_pos;
      up2 = older_row[c];
      up1 = newer_row[c];
      older_row[c] = up1;
      newer_row[c] = px;
      // shift the window left; the new column enters on the right
      nbhd[0] = nbhd[1]; nbhd[1] = nbhd[2]; nbhd[2] = up2;
      nbhd[3] = nbhd[4]; nbhd[4] = nbhd[5]; nbhd[5] = up1;
      nbhd[6] = nbhd[7]; nbhd[7] = nbhd[8]; nbhd[8] = px;
      if (r >= 2 && c >= 2) begin
         ctr = nbhd[4];
         res.code = {nbhd[0] > ctr, nbhd[1] > ctr, nbhd[2] > ctr, nbhd[5] > ctr,
                     nbhd[8] > ctr, nbhd[7] > ctr, nbhd[6] > ctr, nbhd[3] > ctr};
         res.last = (r == h - 1) && (c == w - 1);
         pending_codes.insert(pending_codes.size(), res);
      end
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   task automatic report_mismatch(string msg);
      $display("ERROR (cycle %0d): %s", cycle_count, msg);
      error_count++;
   endtask

   // Track register writes and accepted pixels, check each result transaction
   always @(posedge clock) begin : scoreboard
      pattern_result_type want;
      if (reset) begin
         reset_prediction();
      end else begin
         if (csr_write_en) begin
            if (csr_index == lbp3_pkg::CSR_FRAME_WIDTH) width_reg = csr_write_data;
            else if (csr_index == lbp3_pkg::CSR_FRAME_HEIGHT) height_reg = csr_write_data;
         end
         if (req_valid && !req_stall) begin
            predict_pixel(req_pixel);
            pixels_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_codes.size() == 0) begin
               report_mismatch("result transaction with no code expected");
            end else begin
               want = pending_codes.pop_front();
               codes_checked++;
               if (rsp_pattern_code !== want.code)
                  report_mismatch($sformatf("pattern_code %h, expected %h",
                                            rsp_pattern_code, want.code));
               if (rsp_frame_last !== want.last)
                  report_mismatch($sformatf("frame_last %b, expected %b",
                                            rsp_frame_last, want.last));
               if (want.last) frames_done++;
            end
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic int draw_gap(bit on);
      return on ? int'($urandom_range(0, 8)) : 0;
   endfunction

   // Result side: random stalls per transaction, plus a long hold on request
   initial begin : result_sink
      int n;
      forever begin
         if (hold_request > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_request) @(posedge clock);
            hold_request = 0;
         end
         n = draw_gap(rx_idle_on);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Offer one pixel after a random gap and hold it until accepted
   task automatic send_pixel(logic [PIX_W-1:0] pix);
      int gap;
      gap = draw_gap(tx_idle_on);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= pix;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // Drop valid, wait for every expected code, then let the pipeline settle
   task automatic wait_idle();
      int guard;
      req_valid <= 1'b0;
      guard = 0;
      while (pending_codes.size() != 0 && guard < IDLE_GUARD) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [PIX_W-1:0] next_pixel(fill_kind_type kind,
                                                   logic [PIX_W-1:0] base);
      case (kind)
         FILL_NEAR:    return PIX_W'(int'(base) + int'($urandom_range(0, 4)) - 2);
         FILL_FLAT:    return base;
         FILL_EXTREME: begin
            case ($urandom_range(0, 3))
               0:       return 8'd0;
               1:       return 8'd1;
               2:       return 8'd254;
               default: return 8'd255;
            endcase
         end
         default:      return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_pixels(int unsigned n, fill_kind_type kind);
      logic [PIX_W-1:0] base;
      base = PIX_W'($urandom_range(2, 253));
      repeat (n) send_pixel(next_pixel(kind, base));
   endtask

   // Complete the current frame from the settled position and registers
   task automatic send_frame_rest(fill_kind_type kind);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      w = eff_dim(width_reg, MAX_W);
      h = eff_dim(height_reg, MAX_H);
      c = (col_pos >= w) ? w - 1 : col_pos;
      r = (row_pos >= h) ? h - 1 : row_pos;
      send_pixels((h - r) * w - c, kind);
   endtask

   // Three 3x3 frames: all neighbors brighter, all equal, alternating bits
   task automatic test_directed();
      logic [PIX_W-1:0] dots [27];
      int i;
      dots = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255,
               8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
               8'd129, 8'd127, 8'd129, 8'd127, 8'd128, 8'd127, 8'd129, 8'd127, 8'd129};
      write_csr(lbp3_pkg::CSR_FRAME_WIDTH, 11'd3);
      write_csr(lbp3_pkg::CSR_FRAME_HEIGHT, 11'd3);
      for (i = 0; i < 27; i++) send_pixel(dots[i]);
   endtask

   // Saturating register values: part of the first row at the widest setting,
   // then a small frame finished from the clamped position
   task automatic test_extreme_sizes();
      wait_idle();
      write_csr(lbp3_pkg::CSR_FRAME_WIDTH, 11'd2047);
      write_csr(lbp3_pkg::CSR_FRAME_HEIGHT, 11'd2047);
      send_pixels(EXTREME_PIXELS, FILL_RANDOM);
      wait_idle();
      write_csr(lbp3_pkg::CSR_FRAME_WIDTH, 11'd5);
      write_csr(lbp3_pkg::CSR_FRAME_HEIGHT, 11'd1);
      send_frame_rest(FILL_NEAR);
   endtask

   // Shrink width, then height, partway through a frame
   task automatic test_mid_frame_change();
      wait_idle();
      write_csr(lbp3_pkg::CSR_FRAME_WIDTH, 11'd8);
      write_csr(lbp3_pkg::CSR_FRAME_HEIGHT, 11'd6);
      send_pixels(29, FILL_RANDOM);
      wait_idle();
      write_csr(lbp3_pkg::CSR_FRAME_WIDTH, 11'd4);
      send_frame_rest(FILL_RANDOM);
      wait_idle();
      write_csr(lbp3_pkg::CSR_FRAME_WIDTH, 11'd6);
      write_csr(lbp3_pkg::CSR_FRAME_HEIGHT, 11'd8);
      send_pixels(32, FILL_NEAR);
      wait_idle();
      write_csr(lbp3_pkg::CSR_FRAME_HEIGHT, 11'd4);
      send_frame_rest(FILL_NEAR);
   endtask

   // Hold the result side for a long stretch while pixels keep coming
   task automatic test_backpressure();
      wait_idle();
      write_csr(lbp3_pkg::CSR_FRAME_WIDTH, 11'd10);
      write_csr(lbp3_pkg::CSR_FRAME_HEIGHT, 11'd10);
      tx_idle_on   = 1'b0;
      rx_idle_on   = 1'b0;
      hold_request = 300;
      send_frame_rest(FILL_RANDOM);
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
   endtask

   function automatic logic [DIM_W-1:0] pick_dim(int unsigned hi);
      case ($urandom_range(0, 9))
         0:       return DIM_W'($urandom_range(0, 2));
         1:       return DIM_W'($urandom_range(hi + 1, 40));
         default: return DIM_W'($urandom_range(3, hi));
      endcase
   endfunction

   // Small random frames; some are cut short by a shrinking register write
   task automatic test_random_frames();
      int unsigned   w;
      int unsigned   h;
      int unsigned   start;
      fill_kind_type kind;
      start = pixels_accepted;
      while (pixels_accepted - start < RANDOM_PIXELS) begin
         wait_idle();
         tx_idle_on = ($urandom_range(0, 3) != 0);
         rx_idle_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 3) != 0)
            write_csr(lbp3_pkg::CSR_FRAME_WIDTH, pick_dim(12));
         if ($urandom_range(0, 3) != 0)
            write_csr(lbp3_pkg::CSR_FRAME_HEIGHT, pick_dim(8));
         kind = fill_kind_type'($urandom_range(0, 3));
         if ($urandom_range(0, 7) == 0) begin
            w = eff_dim(width_reg, MAX_W);
            h = eff_dim(height_reg, MAX_H);
            send_pixels($urandom_range(1, w * h - 1), kind);
            wait_idle();
            write_csr(lbp3_pkg::CSR_FRAME_WIDTH, DIM_W'($urandom_range(0, w)));
            write_csr(lbp3_pkg::CSR_FRAME_HEIGHT, DIM_W'($urandom_range(0, h)));
         end
         send_frame_rest(kind);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_extreme_sizes();
      test_mid_frame_change();
      test_backpressure();
      test_random_frames();
      wait_idle();
      if (pending_codes.size() != 0)
         report_mismatch($sformatf("%0d codes never arrived", pending_codes.size()));
      $display("Ran %0d pixels through small and saturated frames, shrinking writes",
               pixels_accepted);
      $display("and a long output hold; checked %0d codes and %0d frame ends",
               codes_checked, frames_done);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
